// ===== src/itoa_pkg.sv =====
// Package: shared types, constants and the digit to character function for the integer to ASCII converter.
package itoa_pkg;
    localparam int ValueW = 32;
    localparam int MaxChars = 11;
    localparam int DigitW = 4;
    localparam int CntW = 4;

    // binary to decimal: bits shifted in per stage, stage count, bcd width
    localparam int DabBits = 8;
    localparam int DabStages = ValueW / DabBits;
    localparam int BcdW = 40;

    localparam logic [1:0] RadixDec = 2'd0;
    localparam logic [1:0] RadixHex = 2'd1;
    localparam logic [1:0] RadixOct = 2'd2;

    localparam logic [6:0] CharMinus = 7'h2D;
    localparam logic [6:0] CharZero = 7'h30;
    localparam logic [6:0] CharLowA = 7'h61;

    typedef logic [DigitW-1:0] digit_t;
    typedef digit_t [MaxChars-1:0] digits_t;

    function automatic logic [6:0] digit_char(input digit_t d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CharZero + {3'd0, d};
        end else begin
            c = CharLowA + {3'd0, d} - 7'd10;
        end
        return c;
    endfunction
endpackage

// ===== src/integer_to_ascii_radix_top.sv =====
// Top level: integer to ASCII converter for radix 10, 16 and 8.
//
// s_axis carries one integer per transfer; m_axis gives its characters,
// most significant first, with m_axis_tlast on the final one.
// An accepted number passes through a five-stage pipeline: sign and
// magnitude, then a shift and add-3 binary to decimal conversion at eight
// bits per stage over four more stages (hex and octal digits are bit
// slices). Digits land in a character buffer which emits one character
// per cycle while m_axis_tready is high.
// The output buffer sets the rate of numbers: it sends one character a cycle
// while m_axis_tready is high, N = 1..11 characters per number, and takes
// the next number only once the last character of the current one has gone.
// The pipeline holds up to five further numbers while the buffer drains,
// so s_axis_tready stays high until the pipe is full.
// Reset (aresetn low, synchronous) drops every number in flight.
// When m_axis_tready is low the current character holds and the
// pipeline fills, then s_axis_tready goes low; nothing is lost.
module integer_to_ascii_radix_top
    import itoa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: value[31:0], is_long[32], signed_conv[33], radix_select[35:34], zero[39:36]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: char_code[6:0], zero[7]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    // stage 0: sign and magnitude; stages 1..DabStages: decimal conversion
    logic [DabStages:0] vld_reg;
    logic [DabStages:0] neg_reg;
    logic [1:0]         rad_reg [DabStages+1];
    logic [ValueW-1:0]  mag_reg [DabStages+1];
    logic [BcdW-1:0]    bcd_reg [DabStages];

    // output buffer
    logic        busy_reg;
    digits_t     buf_reg;
    logic [CntW-1:0] idx_reg;
    logic        sgn_pend_reg;

    logic [DabStages:0] adv;
    logic load;

    assign load = vld_reg[DabStages] && (!busy_reg);

    always_comb begin
        for (int s = 0; s <= DabStages; s++) begin
            adv[s] = load;
            for (int j = s; j <= DabStages; j++) begin
                if (!vld_reg[j]) adv[s] = 1'b1;
            end
        end
    end

    assign s_axis_tready = adv[0];

    // stage 0
    logic [31:0] a_in, m_in;
    logic        n_in, sg_in;
    logic [1:0]  r_in;
    always_comb begin
        r_in = s_axis_tdata[35:34];
        sg_in = s_axis_tdata[33] && (r_in != RadixOct);
        if (s_axis_tdata[32]) begin
            a_in = s_axis_tdata[31:0];
            n_in = sg_in && a_in[31];
        end else begin
            a_in = {16'd0, s_axis_tdata[15:0]};
            n_in = sg_in && a_in[15];
        end
        if (!n_in) begin
            m_in = a_in;
        end else if (s_axis_tdata[32]) begin
            m_in = 32'd0 - a_in;
        end else begin
            m_in = {16'd0, 16'd0 - a_in[15:0]};
        end
    end

    // shift DabBits more bits into the bcd digits, msb first
    function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] b,
                                               input logic [DabBits-1:0] chunk);
        logic [BcdW-1:0] t;
        t = b;
        for (int i = DabBits - 1; i >= 0; i--) begin
            for (int j = 0; j < BcdW / DigitW; j++) begin
                if (t[j*DigitW +: DigitW] >= 4'd5) begin
                    t[j*DigitW +: DigitW] = t[j*DigitW +: DigitW] + 4'd3;
                end
            end
            t = {t[BcdW-2:0], chunk[i]};
        end
        return t;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_axis_tvalid;
            for (int s = 1; s <= DabStages; s++) begin
                if (adv[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
        if (adv[0]) begin
            mag_reg[0] <= m_in;
            neg_reg[0] <= n_in;
            rad_reg[0] <= r_in;
        end
        for (int s = 1; s <= DabStages; s++) begin
            if (adv[s]) begin
                mag_reg[s] <= mag_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                rad_reg[s] <= rad_reg[s-1];
            end
        end
        if (adv[1]) begin
            bcd_reg[0] <= dabble('0, mag_reg[0][ValueW-1 -: DabBits]);
        end
        for (int s = 2; s <= DabStages; s++) begin
            if (adv[s]) begin
                bcd_reg[s-1] <= dabble(bcd_reg[s-2],
                                       mag_reg[s-1][ValueW-1-(s-1)*DabBits -: DabBits]);
            end
        end
    end

    // digit vector, least significant first
    digits_t dg;
    always_comb begin
        dg = '0;
        case (rad_reg[DabStages])
            RadixHex: begin
                for (int i = 0; i < 8; i++) dg[i] = mag_reg[DabStages][i*4 +: 4];
            end
            RadixOct: begin
                for (int i = 0; i < 10; i++) dg[i] = {1'b0, mag_reg[DabStages][i*3 +: 3]};
                dg[10] = {2'b00, mag_reg[DabStages][31:30]};
            end
            default: begin
                for (int i = 0; i < BcdW / DigitW; i++) begin
                    dg[i] = bcd_reg[DabStages-1][i*DigitW +: DigitW];
                end
            end
        endcase
    end

    logic [CntW-1:0] top_idx;
    always_comb begin
        top_idx = '0;
        for (int i = 1; i < MaxChars; i++) begin
            if (dg[i] != '0) top_idx = CntW'(i);
        end
    end

    logic fire;
    assign fire = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (fire && !sgn_pend_reg && idx_reg == '0) begin
            busy_reg <= 1'b0;
        end
        if (load) begin
            buf_reg <= dg;
            idx_reg <= top_idx;
            sgn_pend_reg <= neg_reg[DabStages];
        end else if (fire) begin
            if (sgn_pend_reg) begin
                sgn_pend_reg <= 1'b0;
            end else if (idx_reg != '0) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata = {1'b0, sgn_pend_reg ? CharMinus : digit_char(buf_reg[idx_reg])};
    assign m_axis_tlast = !sgn_pend_reg && (idx_reg == '0);
endmodule

// ===== verif/testbench.sv =====
// Testbench for integer_to_ascii_radix_top: directed and random numbers, char-by-char check.
`timescale 1ns / 100ps

module testbench
    import itoa_pkg::*;
();

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } ascii_char_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    ascii_char_t pending_chars[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          burst_left;
    bit          stall_enable;

    localparam int CycleLimit = 400000;

    integer_to_ascii_radix_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic predict_chars(input logic [31:0] value, input logic is_long,
                                 input logic signed_conv, input logic [1:0] radix);
        logic [31:0] mag;
        logic [31:0] base;
        logic [6:0]  digits[$];
        logic        neg;
        logic [3:0]  d;
        ascii_char_t c;
        base = (radix == RadixHex) ? 32'd16 : (radix == RadixOct) ? 32'd8 : 32'd10;
        neg = 1'b0;
        mag = is_long ? value : {16'd0, value[15:0]};
        if (signed_conv && radix != RadixOct) begin
            if (is_long && mag[31]) begin
                neg = 1'b1;
                mag = 32'd0 - mag;
            end else if (!is_long && mag[15]) begin
                neg = 1'b1;
                mag = (32'h10000 - mag) & 32'hFFFF;
            end
        end
        if (mag == 0) digits.push_front(CharZero);
        while (mag != 0) begin
            d = 4'(mag % base);
            digits.push_front(d < 10 ? CharZero + 7'(d) : CharLowA + 7'(d) - 7'd10);
            mag = mag / base;
        end
        if (neg) digits.push_front(CharMinus);
        foreach (digits[i]) begin
            c.code = digits[i];
            c.last = (i == digits.size() - 1);
            pending_chars.push_back(c);
        end
    endtask

    task automatic send_number(input logic [31:0] value, input logic is_long,
                               input logic signed_conv, input logic [1:0] radix);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tdata  <= {4'd0, radix, signed_conv, is_long, value};
        s_axis_tvalid <= 1'b1;
        predict_chars(value, is_long, signed_conv, radix);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic finish_sending;
        s_axis_tvalid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        ascii_char_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected transfer char_code=%h", m_axis_tdata[6:0]);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_axis_tdata[6:0] !== want.code) begin
                    $error("char_code expected %h actual %h", want.code, m_axis_tdata[6:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last expected %b actual %b", want.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tdata[7] !== 1'b0) begin
                    $error("tdata pad expected 0 actual %b", m_axis_tdata[7]);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!stall_enable) m_axis_tready <= 1'b1;
        else m_axis_tready <= ((cycle_count / 40) % 3 == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        if (cycle_count > CycleLimit) begin
            $display("[integer_to_ascii_radix_top] ERROR");
            $finish;
        end
    end

    task automatic test_extremes;
        send_number(32'h0000_0000, 1'b1, 1'b0, RadixDec);
        send_number(32'hFFFF_FFFF, 1'b1, 1'b0, RadixDec);
        send_number(32'hFFFF_FFFF, 1'b1, 1'b0, RadixOct);
        send_number(32'hFFFF_FFFF, 1'b1, 1'b0, RadixHex);
        send_number(32'h8000_0000, 1'b1, 1'b1, RadixDec);
        send_number(32'h8000_0000, 1'b1, 1'b1, RadixHex);
        send_number(32'hFFFF_8000, 1'b0, 1'b1, RadixDec);
        send_number(32'h1234_FFFF, 1'b0, 1'b1, RadixDec);
        send_number(32'hABCD_FFFF, 1'b0, 1'b0, RadixDec);
        send_number(32'h0001_0000, 1'b0, 1'b1, RadixHex);
        send_number(32'h7FFF_FFFF, 1'b1, 1'b1, RadixDec);
        send_number(32'h0000_7FFF, 1'b0, 1'b1, RadixDec);
    endtask

    task automatic test_radix_cases;
        send_number(32'hDEAD_BEEF, 1'b1, 1'b0, RadixHex);
        send_number(32'hDEAD_BEEF, 1'b1, 1'b1, RadixHex);
        send_number(32'hFFFF_FFFF, 1'b1, 1'b1, RadixOct);
        send_number(32'h0000_8000, 1'b0, 1'b1, RadixOct);
        send_number(32'hFFFF_FFF6, 1'b1, 1'b1, 2'd3);
        send_number(32'd1234567890, 1'b1, 1'b0, 2'd3);
        send_number(32'd9, 1'b1, 1'b0, RadixDec);
        send_number(32'd10, 1'b0, 1'b0, RadixDec);
        send_number(32'd0, 1'b0, 1'b1, RadixOct);
    endtask

    task automatic test_random;
        logic [31:0] v;
        for (int i = 0; i < 260; i++) begin
            v = $urandom();
            case ($urandom_range(0, 3))
                0: v = v >> $urandom_range(0, 31);
                1: v = ~(v >> $urandom_range(0, 31));
                default: ;
            endcase
            stall_enable = (i % 80) >= 20;
            send_number(v, 1'($urandom()), 1'($urandom()), 2'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 0;
        stall_enable  = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_extremes();
        test_radix_cases();
        test_random();
        finish_sending();
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[integer_to_ascii_radix_top] OK");
        end else begin
            $display("[integer_to_ascii_radix_top] ERROR");
        end
        $finish;
    end
endmodule
